// ===== rtl/bfsa_pkg.sv =====
// Package for the best-fit segment allocator: opcodes, status codes and field widths.
// It depends on nothing else and is used by every module under rtl.
`default_nettype none
package bfsa_pkg;
  localparam int unsigned SizeW = 21;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARG  = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MERGE,
    S_OUT
  } state_e;

  // Commands sent along the row of cells. Every cell acts in the same cycle.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_SPLIT,
    CMD_TAKE,
    CMD_MARK_FREE,
    CMD_MERGE_UP
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [9:0] idx;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/bfsa_cell.sv =====
// One table slot of the allocator: start, payload size, free flag, occupancy.
// Depends on bfsa_pkg; shifts entries towards or away from its neighbours.
`default_nettype none
module bfsa_cell #(
  parameter int unsigned AddrW = 20,
  parameter int unsigned IdxW  = 6,
  parameter int unsigned HdrB  = 24
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire  [IdxW-1:0]          my_idx_i,
  input  bfsa_pkg::cell_ctl_t      ctl_i,
  input  wire  [bfsa_pkg::SizeW-1:0] init_pay_i,
  input  wire                      init_use_i,
  input  wire  [bfsa_pkg::SizeW-1:0] req_i,
  // neighbour below (index - 1)
  input  wire  [AddrW-1:0]         lo_start_i,
  input  wire  [bfsa_pkg::SizeW-1:0] lo_pay_i,
  input  wire                      lo_free_i,
  input  wire                      lo_used_i,
  // neighbour above (index + 1)
  input  wire  [AddrW-1:0]         hi_start_i,
  input  wire  [bfsa_pkg::SizeW-1:0] hi_pay_i,
  input  wire                      hi_free_i,
  input  wire                      hi_used_i,
  output logic [AddrW-1:0]         start_o,
  output logic [bfsa_pkg::SizeW-1:0] pay_o,
  output logic                     free_o,
  output logic                     used_o
);
  logic [AddrW-1:0]           start_q, start_d;
  logic [bfsa_pkg::SizeW-1:0] pay_q, pay_d;
  logic                       free_q, free_d, used_q, used_d;
  logic [IdxW-1:0]            t;
  logic [bfsa_pkg::SizeW+1:0] lo_rem;

  assign t = ctl_i.idx[IdxW-1:0];
  // remainder payload of the split segment below
  assign lo_rem = {2'b0, lo_pay_i} - {2'b0, req_i} - (bfsa_pkg::SizeW+2)'(HdrB);

  // Apply the broadcast command to this slot
  always_comb begin
    start_d = start_q;
    pay_d   = pay_q;
    free_d  = free_q;
    used_d  = used_q;
    unique case (ctl_i.cmd)
      bfsa_pkg::CMD_INIT: begin
        start_d = '0;
        pay_d   = init_pay_i;
        free_d  = 1'b1;
        used_d  = (my_idx_i == '0) && init_use_i;
      end
      bfsa_pkg::CMD_SPLIT: begin
        if (my_idx_i == t) begin
          pay_d  = req_i;
          free_d = 1'b0;
        end else if (my_idx_i == t + IdxW'(1)) begin
          start_d = lo_start_i + AddrW'(HdrB) + req_i[AddrW-1:0];
          pay_d   = lo_rem[bfsa_pkg::SizeW-1:0];
          free_d  = 1'b1;
          used_d  = 1'b1;
        end else if (my_idx_i > t + IdxW'(1)) begin
          start_d = lo_start_i;
          pay_d   = lo_pay_i;
          free_d  = lo_free_i;
          used_d  = lo_used_i;
        end
      end
      // hand out the whole segment
      bfsa_pkg::CMD_TAKE: begin
        if (my_idx_i == t) free_d = 1'b0;
      end
      bfsa_pkg::CMD_MARK_FREE: begin
        if (my_idx_i == t) free_d = 1'b1;
      end
      bfsa_pkg::CMD_MERGE_UP: begin
        if (my_idx_i == t) begin
          pay_d = pay_q + bfsa_pkg::SizeW'(HdrB) + hi_pay_i;
        end else if (my_idx_i > t) begin
          start_d = hi_start_i;
          pay_d   = hi_pay_i;
          free_d  = hi_free_i;
          used_d  = hi_used_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      free_q <= 1'b0;
    end else begin
      used_q <= used_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    pay_q   <= pay_d;
  end

  assign start_o = start_q;
  assign pay_o   = pay_q;
  assign free_o  = free_q;
  assign used_o  = used_q;
endmodule
`default_nettype wire

// ===== rtl/bfsa_search.sv =====
// Registered reduction over the row of cells: best-fit pick and address lookup.
// Depends on bfsa_pkg; fed by the cell outputs of the top level.
`default_nettype none
module bfsa_search #(
  parameter int unsigned N     = 64,
  parameter int unsigned AddrW = 20,
  parameter int unsigned IdxW  = 6,
  parameter int unsigned HdrB  = 24
) (
  input  wire                              clk_i,
  input  wire  [N-1:0][AddrW-1:0]          start_i,
  input  wire  [N-1:0][bfsa_pkg::SizeW-1:0] pay_i,
  input  wire  [N-1:0]                     free_i,
  input  wire  [N-1:0]                     used_i,
  input  wire  [bfsa_pkg::SizeW-1:0]       req_i,
  input  wire  [AddrW-1:0]                 addr_i,
  output logic                             fit_found_o,
  output logic [IdxW-1:0]                  fit_idx_o,
  output logic                             hit_found_o,
  output logic [IdxW-1:0]                  hit_idx_o
);
  localparam int unsigned P = 1 << IdxW;

  logic [N-1:0] fit_q, hit_q;
  logic [N-1:0][bfsa_pkg::SizeW-1:0] pay_q;

  // Stage one: per-slot candidacy, all slots in parallel
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      fit_q[i] <= used_i[i] && free_i[i] && (pay_i[i] >= req_i);
      hit_q[i] <= used_i[i] && !free_i[i] &&
                  ({1'b0, addr_i} >= {1'b0, start_i[i]} + (AddrW+1)'(HdrB)) &&
                  ({2'b0, addr_i} < {2'b0, start_i[i]} + (AddrW+2)'(HdrB)
                                   + (AddrW+2)'(pay_i[i]));
      pay_q[i] <= pay_i[i];
    end
  end

  // Stage two: pairwise tree, smallest fitting payload, lower index wins ties
  always_comb begin
    logic [P-1:0]                       fv, hv;
    logic [P-1:0][bfsa_pkg::SizeW-1:0]  fp;
    logic [P-1:0][IdxW-1:0]             fi, hi;
    for (int i = 0; i < P; i++) begin
      fi[i] = IdxW'(i);
      hi[i] = IdxW'(i);
      if (i < N) begin
        fv[i] = fit_q[i];
        hv[i] = hit_q[i];
        fp[i] = pay_q[i];
      end else begin
        fv[i] = 1'b0;
        hv[i] = 1'b0;
        fp[i] = '0;
      end
    end
    for (int w = P / 2; w >= 1; w = w >> 1) begin
      for (int i = 0; i < w; i++) begin
        if (fv[2*i+1] && (!fv[2*i] || fp[2*i+1] < fp[2*i])) begin
          fp[i] = fp[2*i+1];
          fi[i] = fi[2*i+1];
        end else begin
          fp[i] = fp[2*i];
          fi[i] = fi[2*i];
        end
        fv[i] = fv[2*i] | fv[2*i+1];
        hi[i] = hv[2*i] ? hi[2*i] : hi[2*i+1];
        hv[i] = hv[2*i] | hv[2*i+1];
      end
    end
    fit_found_o = fv[0];
    fit_idx_o   = fi[0];
    hit_found_o = hv[0];
    hit_idx_o   = hi[0];
  end
endmodule
`default_nettype wire

// ===== rtl/best_fit_segment_allocator_top.sv =====
// Top level of the best-fit segment allocator: stream ports, sequencer, row of cells.
// Depends on bfsa_pkg, bfsa_cell and bfsa_search.
`default_nettype none
// One beat is taken at a time; the next is taken only after its result has gone out.
// Search registers candidacy, then does the best-fit reduce, and an allocate edits
// the table in the reduce step; a free then checks and merges its neighbour above
// and then its neighbour below, and the result stays in an output register until
// taken. Each table slot is a cell that shifts its entry to a neighbour on insert
// or removal, so every table edit is a single broadcast command regardless of
// position. Writing region_bytes rebuilds the table with one broadcast command.
module best_fit_segment_allocator_top #(
  parameter int unsigned MAX_SEGMENTS     = 64,
  parameter int unsigned HEADER_BYTES     = 24,
  parameter int unsigned MIN_SPLIT_BYTES  = 8,
  parameter int unsigned REGION_ADDR_BITS = 20
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [20:0]  cfg_wdata_i,      // region_bytes
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [47:0]  s_axis_tdata,     // op[1:0], req_size[22:2], address[42:23]
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [47:0]  m_axis_tdata      // status[1:0], payload_offset[21:2],
                                         // payload_bytes[42:22], is_valid[43]
);
  localparam int unsigned N     = MAX_SEGMENTS;
  localparam int unsigned IdxW  = $clog2(N);
  localparam int unsigned AddrW = REGION_ADDR_BITS;
  localparam int unsigned SW    = bfsa_pkg::SizeW;

  bfsa_pkg::state_e st_q, st_d;
  bfsa_pkg::op_e    op_q;
  logic [SW-1:0]    req_q;
  logic [AddrW-1:0] addr_q;
  logic [1:0]       wait_q, wait_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW:0]    cnt_q, cnt_d;
  logic             merge_hi_q, merge_hi_d;

  bfsa_pkg::status_e res_st_q, res_st_d;
  logic [19:0]      res_off_q, res_off_d;
  logic [SW-1:0]    res_pay_q, res_pay_d;
  logic             res_val_q, res_val_d;

  logic [SW-1:0]    region_sat;
  logic [SW-1:0]    init_pay;
  logic             init_use;
  bfsa_pkg::cell_ctl_t ctl;

  logic [N-1:0][AddrW-1:0] c_start;
  logic [N-1:0][SW-1:0]    c_pay;
  logic [N-1:0]            c_free, c_used;
  logic                    fit_found, hit_found;
  logic [IdxW-1:0]         fit_idx, hit_idx;

  // Saturate the region size to the address space
  always_comb begin
    region_sat = cfg_wdata_i;
    if ({1'b0, cfg_wdata_i} > (SW+1)'(64'd1 << AddrW)) region_sat = SW'(64'd1 << AddrW);
    init_use = region_sat > SW'(HEADER_BYTES);
    init_pay = region_sat - SW'(HEADER_BYTES);
  end

  // Row of cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    bfsa_cell #(.AddrW(AddrW), .IdxW(IdxW), .HdrB(HEADER_BYTES)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .my_idx_i(IdxW'(g)), .ctl_i(ctl),
      .init_pay_i(init_pay), .init_use_i(init_use), .req_i(req_q),
      .lo_start_i(c_start[(g == 0) ? 0 : g-1]), .lo_pay_i(c_pay[(g == 0) ? 0 : g-1]),
      .lo_free_i(c_free[(g == 0) ? 0 : g-1]), .lo_used_i(c_used[(g == 0) ? 0 : g-1]),
      .hi_start_i(c_start[(g == N-1) ? g : g+1]), .hi_pay_i(c_pay[(g == N-1) ? g : g+1]),
      .hi_free_i(c_free[(g == N-1) ? g : g+1]),
      .hi_used_i((g == N-1) ? 1'b0 : c_used[(g == N-1) ? g : g+1]),
      .start_o(c_start[g]), .pay_o(c_pay[g]), .free_o(c_free[g]), .used_o(c_used[g])
    );
  end

  bfsa_search #(.N(N), .AddrW(AddrW), .IdxW(IdxW), .HdrB(HEADER_BYTES)) u_search (
    .clk_i(clk_i), .start_i(c_start), .pay_i(c_pay), .free_i(c_free), .used_i(c_used),
    .req_i(req_q), .addr_i(addr_q), .fit_found_o(fit_found), .fit_idx_o(fit_idx),
    .hit_found_o(hit_found), .hit_idx_o(hit_idx)
  );

  // Sequencer state and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bfsa_pkg::S_IDLE;
      wait_q <= '0;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      wait_q <= wait_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= bfsa_pkg::op_e'(s_axis_tdata[1:0]);
      req_q  <= s_axis_tdata[22:2];
      addr_q <= AddrW'(s_axis_tdata[42:23]);
    end
    idx_q <= idx_d;
    merge_hi_q <= merge_hi_d;
    res_st_q <= res_st_d;
    res_off_q <= res_off_d;
    res_pay_q <= res_pay_d;
    res_val_q <= res_val_d;
  end

  // Next state, cell commands and result
  always_comb begin
    logic [SW+1:0] rem;
    rem = '0;
    st_d = st_q;
    wait_d = wait_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    merge_hi_d = merge_hi_q;
    res_st_d = res_st_q;
    res_off_d = res_off_q;
    res_pay_d = res_pay_q;
    res_val_d = res_val_q;
    ctl.cmd = bfsa_pkg::CMD_NONE;
    ctl.idx = 10'(idx_q);
    s_axis_tready = (st_q == bfsa_pkg::S_IDLE);
    m_axis_tvalid = (st_q == bfsa_pkg::S_OUT);
    if (cfg_we_i) begin
      ctl.cmd = bfsa_pkg::CMD_INIT;
      cnt_d = init_use ? (IdxW+1)'(1) : '0;
    end
    unique case (st_q)
      bfsa_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          st_d = bfsa_pkg::S_SEARCH;
          wait_d = '0;
        end
      end
      bfsa_pkg::S_SEARCH: begin
        wait_d = wait_q + 2'd1;
        if (wait_q == 2'd1) begin
          res_st_d = bfsa_pkg::ST_BAD_ARG;
          res_off_d = '0;
          res_pay_d = '0;
          res_val_d = 1'b0;
          st_d = bfsa_pkg::S_OUT;
          unique case (op_q)
            bfsa_pkg::OP_ALLOC: begin
              if (req_q != '0) begin
                if (!fit_found) res_st_d = bfsa_pkg::ST_NO_FIT;
                else begin
                  rem = {2'b0, c_pay[fit_idx]} - {2'b0, req_q};
                  res_st_d = bfsa_pkg::ST_OK;
                  res_off_d = 20'(c_start[fit_idx] + AddrW'(HEADER_BYTES));
                  idx_d = fit_idx;
                  ctl.idx = 10'(fit_idx);
                  if (rem >= (SW+2)'(HEADER_BYTES + MIN_SPLIT_BYTES) &&
                      cnt_q < (IdxW+1)'(N)) begin
                    ctl.cmd = bfsa_pkg::CMD_SPLIT;
                    cnt_d = cnt_q + 1'b1;
                    res_pay_d = req_q;
                  end else begin
                    ctl.cmd = bfsa_pkg::CMD_TAKE;
                    res_pay_d = c_pay[fit_idx];
                  end
                end
              end
            end
            bfsa_pkg::OP_FREE, bfsa_pkg::OP_QUERY: begin
              if (!hit_found) res_st_d = bfsa_pkg::ST_NOT_USED;
              else begin
                res_st_d = bfsa_pkg::ST_OK;
                res_off_d = 20'(c_start[hit_idx] + AddrW'(HEADER_BYTES));
                res_pay_d = c_pay[hit_idx];
                if (op_q == bfsa_pkg::OP_QUERY) res_val_d = 1'b1;
                else begin
                  ctl.cmd = bfsa_pkg::CMD_MARK_FREE;
                  ctl.idx = 10'(hit_idx);
                  idx_d = hit_idx;
                  merge_hi_d = 1'b1;
                  st_d = bfsa_pkg::S_MERGE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      bfsa_pkg::S_MERGE: begin
        if (merge_hi_q) begin
          merge_hi_d = 1'b0;
          if ((IdxW+1)'(idx_q) + 1'b1 < cnt_q && c_free[idx_q + 1'b1]) begin
            ctl.cmd = bfsa_pkg::CMD_MERGE_UP;
            cnt_d = cnt_q - 1'b1;
          end
        end else begin
          st_d = bfsa_pkg::S_OUT;
          if (idx_q != '0 && c_free[idx_q - 1'b1]) begin
            ctl.cmd = bfsa_pkg::CMD_MERGE_UP;
            ctl.idx = 10'(idx_q - 1'b1);
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      bfsa_pkg::S_OUT: begin
        if (m_axis_tready) st_d = bfsa_pkg::S_IDLE;
      end
      default: st_d = bfsa_pkg::S_IDLE;
    endcase
  end

  assign m_axis_tdata = {4'b0, res_val_q, res_pay_q, res_off_q, res_st_q};
endmodule
`default_nettype wire
